FILE: hdl/eth_l4p_pkg.sv
// ============================================================================
// eth_l4p_pkg: shared types and constants for the L2-L4 header parser
// Holds the capture record that the front part hands to the back part.
// ============================================================================
package eth_l4p_pkg;

  localparam logic [7:0]  EthLen       = 8'd14;
  localparam logic [15:0] EtypeIpv4    = 16'h0800;
  localparam logic [15:0] EtypeIpv6    = 16'h86DD;
  localparam logic [15:0] EtypeArp     = 16'h0806;
  localparam logic [7:0]  ProtoIcmp    = 8'd1;
  localparam logic [7:0]  ProtoTcp     = 8'd6;
  localparam logic [7:0]  ProtoUdp     = 8'd17;
  localparam logic [1:0]  KindDrop     = 2'd0;
  localparam logic [1:0]  KindIpv4     = 2'd1;
  localparam logic [1:0]  KindIpv6     = 2'd2;
  localparam logic [1:0]  KindArp      = 2'd3;

  // Everything the front part captured for one frame.
  typedef struct packed {
    logic [16:0] caplen;
    logic [15:0] ethertype;
    logic [6:0]  ip_hlen;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] port_pair;
    logic [6:0]  tcp_hlen;
    logic [7:0]  icmp_type;
  } eth_l4p_cap_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic        icmp_valid;
    logic [7:0]  icmp_kind;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;
  } eth_l4p_res_t;

endpackage

FILE: hdl/eth_l4p_front.sv
// ============================================================================
// eth_l4p_front: byte capture
// Counts frame bytes and latches header fields as they go by; emits one
// capture record on each last byte.
// ============================================================================
module eth_l4p_front import eth_l4p_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         byte_vld,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output logic         cap_vld,
  output eth_l4p_cap_t cap
);

  localparam logic [16:0] MaxBytes = 17'(MAX_FRAME_BYTES);

  eth_l4p_cap_t st_r, st_nxt, upd;
  logic [16:0]  p;
  logic [16:0]  l3;
  logic         is_ip;
  logic [16:0]  d;

  always_comb begin
    p   = st_r.caplen;
    upd = st_r;
    l3  = '0;
    is_ip = 1'b0;
    d = '0;
    if (p < MaxBytes) begin
      if (p == 17'd12) upd.ethertype = {data_byte, 8'h00};
      else if (p == 17'd13) upd.ethertype = {st_r.ethertype[15:8], data_byte};
      if (p >= 17'(EthLen)) begin
        if (st_r.ethertype == EtypeIpv4) begin
          is_ip = 1'b1;
          if (p == 17'd14) upd.ip_hlen = {1'b0, data_byte[3:0], 2'b00};
          else if (p == 17'd23) upd.protocol = data_byte;
          else if (p >= 17'd26 && p <= 17'd29)
            upd.src_addr = {st_r.src_addr[23:0], data_byte};
          else if (p >= 17'd30 && p <= 17'd33)
            upd.dst_addr = {st_r.dst_addr[23:0], data_byte};
          // The header length taken from this very byte already counts.
          l3 = 17'(EthLen) + 17'(upd.ip_hlen);
        end else if (st_r.ethertype == EtypeIpv6) begin
          is_ip = 1'b1;
          if (p == 17'd20) upd.protocol = data_byte;
          l3 = 17'd54;
        end
        if (is_ip) begin
          d = p - l3;
          if (p >= l3 && d < 17'd4) begin
            case (d[1:0])
              2'd0: begin
                upd.port_pair[31:24] = data_byte;
                upd.icmp_type = data_byte;
              end
              2'd1: upd.port_pair[23:16] = data_byte;
              2'd2: upd.port_pair[15:8] = data_byte;
              default: upd.port_pair[7:0] = data_byte;
            endcase
          end
          if (p == l3 + 17'd12) upd.tcp_hlen = {1'b0, data_byte[7:4], 2'b00};
        end
      end
      upd.caplen = p + 17'd1;
    end
    st_nxt = st_r;
    if (byte_vld) st_nxt = last_byte ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      cap_vld <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cap_vld <= byte_vld && last_byte;
    end
    cap <= upd;
  end

endmodule

FILE: hdl/eth_l4p_back.sv
// ============================================================================
// eth_l4p_back: classification
// Turns a capture record into a result, one record per cycle, registered.
// ============================================================================
module eth_l4p_back import eth_l4p_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cap_vld,
  input  eth_l4p_cap_t cap,
  output logic         res_vld,
  output eth_l4p_res_t res
);

  eth_l4p_res_t r;
  logic [16:0]  rem, rem2;
  logic [7:0]   off;
  logic         ok;

  always_comb begin
    r   = '0;
    ok  = 1'b1;
    rem = cap.caplen - 17'(EthLen);
    rem2 = rem;
    off = EthLen;
    if (cap.caplen < 17'(EthLen)) begin
      ok = 1'b0;
    end else if (cap.ethertype == EtypeIpv4 && rem >= 17'd20) begin
      if (cap.ip_hlen < 7'd20 || rem < 17'(cap.ip_hlen)) ok = 1'b0;
      r.frame_kind = KindIpv4;
      r.source_address = cap.src_addr;
      r.destination_address = cap.dst_addr;
      off = off + 8'(cap.ip_hlen);
      rem2 = rem - 17'(cap.ip_hlen);
    end else if (cap.ethertype == EtypeIpv6 && rem >= 17'd40) begin
      r.frame_kind = KindIpv6;
      off = off + 8'd40;
      rem2 = rem - 17'd40;
    end else if (cap.ethertype == EtypeArp) begin
      ok = 1'b0;
      r = '0;
      r.frame_kind = KindArp;
    end else begin
      ok = 1'b0;
    end
    if (ok) begin
      r.ip_protocol = cap.protocol;
      if (cap.protocol == ProtoTcp && rem2 >= 17'd20) begin
        if (cap.tcp_hlen < 7'd20 || rem2 < 17'(cap.tcp_hlen)) ok = 1'b0;
        r.source_port = cap.port_pair[31:16];
        r.destination_port = cap.port_pair[15:0];
        off = off + 8'(cap.tcp_hlen);
        rem2 = rem2 - 17'(cap.tcp_hlen);
      end else if (cap.protocol == ProtoUdp && rem2 >= 17'd8) begin
        r.source_port = cap.port_pair[31:16];
        r.destination_port = cap.port_pair[15:0];
        off = off + 8'd8;
        rem2 = rem2 - 17'd8;
      end else if (cap.protocol == ProtoIcmp && rem2 >= 17'd4) begin
        r.icmp_valid = 1'b1;
        r.icmp_kind = cap.icmp_type;
      end
      r.payload_offset = off;
      r.payload_length = rem2[16] ? 16'hFFFF : rem2[15:0];
      if (!ok) r = '0;
    end else if (r.frame_kind != KindArp) begin
      r = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_vld <= 1'b0;
    else res_vld <= cap_vld;
    res <= r;
  end

endmodule

FILE: hdl/eth_l4p_fifo.sv
// ============================================================================
// eth_l4p_fifo: result queue
// Small FIFO of results behind a registered output word; full is raised early
// enough to cover the words still in flight in the capture and classification
// registers.
// ============================================================================
module eth_l4p_fifo import eth_l4p_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  eth_l4p_res_t wdata,
  input  logic         rd,
  output logic         empty,
  output logic         afull,
  output eth_l4p_res_t rdata
);

  localparam int AW = $clog2(DEPTH);

  eth_l4p_res_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   mcnt_r;
  logic [AW:0]   cnt_r;
  logic          out_vld_r;
  eth_l4p_res_t  out_r;
  logic          load, from_mem, bypass, mem_wr;

  assign empty    = !out_vld_r;
  assign afull    = (cnt_r >= (AW+1)'(DEPTH - 2));
  assign rdata    = out_r;
  // The output word is refilled whenever it is free or being taken.
  assign load     = !out_vld_r || rd;
  assign from_mem = load && (mcnt_r != '0);
  assign bypass   = load && (mcnt_r == '0) && wr;
  assign mem_wr   = wr && !bypass;

  always_ff @(posedge clk) begin
    if (mem_wr) mem[wp_r] <= wdata;
    if (from_mem) out_r <= mem[rp_r];
    else if (bypass) out_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      rp_r      <= '0;
      mcnt_r    <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (mem_wr) wp_r <= wp_r + 1'b1;
      if (from_mem) rp_r <= rp_r + 1'b1;
      mcnt_r <= mcnt_r + (AW+1)'(mem_wr) - (AW+1)'(from_mem);
      if (load) out_vld_r <= from_mem || bypass;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

FILE: hdl/ethernet_ip_l4_header_parser.sv
// ============================================================================
// ethernet_ip_l4_header_parser: Ethernet/IPv4/IPv6/TCP/UDP/ICMP header parser
// Streams frame bytes in and queues one classification word per frame.
// ============================================================================
// Frame bytes are pushed one word per clock while in_full is low, wire order,
// with in_last_byte on the final byte. The capture stage latches header
// fields on the fly, so a byte is taken every cycle while in_full is low;
// after the last byte, the frame's result word passes the capture and the
// classification registers and enters a result queue of four entries behind
// a registered output word, where it is shown while out_empty is low. in_full
// rises once two result words are held, early enough that the words still in
// those registers always find room: no result is lost while the reader stalls.
// Bytes beyond MAX_FRAME_BYTES are ignored but a last byte still ends the
// frame. Dropped frames still yield a word with every field zero.
module ethernet_ip_l4_header_parser import eth_l4p_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_frame_kind,
  output logic [7:0]  out_ip_protocol,
  output logic [31:0] out_source_address,
  output logic [31:0] out_destination_address,
  output logic [15:0] out_source_port,
  output logic [15:0] out_destination_port,
  output logic        out_icmp_valid,
  output logic [7:0]  out_icmp_kind,
  output logic [7:0]  out_payload_offset,
  output logic [15:0] out_payload_length
);

  logic         acc, cap_vld, res_vld, afull;
  eth_l4p_cap_t cap;
  eth_l4p_res_t res, q;

  assign in_full = afull;
  assign acc = in_push && !in_full;

  eth_l4p_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk, .rst_n, .byte_vld(acc), .data_byte(in_data_byte),
    .last_byte(in_last_byte), .cap_vld, .cap
  );

  eth_l4p_back u_back (.clk, .rst_n, .cap_vld, .cap, .res_vld, .res);

  eth_l4p_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst_n, .wr(res_vld), .wdata(res), .rd(out_pop && !out_empty),
    .empty(out_empty), .afull, .rdata(q)
  );

  assign out_frame_kind          = q.frame_kind;
  assign out_ip_protocol         = q.ip_protocol;
  assign out_source_address      = q.source_address;
  assign out_destination_address = q.destination_address;
  assign out_source_port         = q.source_port;
  assign out_destination_port    = q.destination_port;
  assign out_icmp_valid          = q.icmp_valid;
  assign out_icmp_kind           = q.icmp_kind;
  assign out_payload_offset      = q.payload_offset;
  assign out_payload_length      = q.payload_length;

endmodule
